// File: hdl/qte_pkg.sv
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int CS_USED = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  localparam int QW  = 16;   // Q1.14 input field
  localparam int PW  = 32;   // 16x16 product
  localparam int RW  = 34;   // atan2 numerator / denominator in Q28
  localparam int SW  = 30;   // clamped asin argument
  localparam int VW  = 58;   // radicand, padded to an even width
  localparam int SQ_STEPS = VW / 2;
  localparam int RTW = SQ_STEPS;  // root width
  localparam int REMW = RTW + 3;
  localparam int CW  = 38;   // CORDIC x/y
  localparam int ZW  = 28;   // CORDIC angle, Q24

  localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [RW-1:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [ZW-1:0] PI_Q13 = 28'sd25736;
  localparam logic signed [ZW-1:0] HALF_PI_Q13 = 28'sd12868;
  localparam logic signed [ZW-1:0] ONE_RAD_Q13 = 28'sd8192;

  typedef struct packed {
    logic signed [RW-1:0] rn;
    logic signed [RW-1:0] rd;
    logic signed [RW-1:0] yn;
    logic signed [RW-1:0] yd;
    logic signed [SW-1:0] s;
  } args_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = (idx < TABLE_LEN) ? ZW'(28'sd1 <<< (24 - idx)) : '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/qte_if.sv
`default_nettype none
interface qte_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic signed [14:0] cmd_pitch;
  logic signed [14:0] cmd_roll;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, cmd_pitch, cmd_roll,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, cmd_pitch, cmd_roll,
                output ready);
endinterface
`default_nettype wire

// File: hdl/quaternion_to_euler_clamp.sv
`default_nettype none
// Quaternion (Q1.14) to Z-Y-X Euler angles (Q2.13, pitch Q1.13) with a
// clamped attitude command. Fully pipelined: one item per cycle, through
// 3 product/argument stages, 29 square-root steps for the asin cosine term,
// one pre-rotation and one stage per CORDIC iteration, and one output
// register. The whole pipe advances together when the output register is
// empty or being taken; a stalled output holds every stage.
module quaternion_to_euler_clamp (
  input  logic            clk,
  input  logic            rst_n,
  qte_in_if.sink          in_ch,
  qte_out_if.source       out_ch
);
  import qte_pkg::*;

  localparam int PIPE = 3 + SQ_STEPS + 1 + CS_USED;

  logic en;
  logic out_valid_r;
  logic vld_r [0:PIPE-1];
  logic zq_r  [0:PIPE-1];

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < PIPE; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zq_r[0] <= (in_ch.quat_w == 0) && (in_ch.quat_x == 0) &&
                 (in_ch.quat_y == 0) && (in_ch.quat_z == 0);
      for (int i = 1; i < PIPE; i++) zq_r[i] <= zq_r[i-1];
    end
  end

  // products
  logic signed [PW-1:0] ww_r, xx_r, yy_r, wx_r, zy_r, zw_r, xy_r, yw_r, zx_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= PW'(in_ch.quat_w * in_ch.quat_w);
      xx_r <= PW'(in_ch.quat_x * in_ch.quat_x);
      yy_r <= PW'(in_ch.quat_y * in_ch.quat_y);
      wx_r <= PW'(in_ch.quat_w * in_ch.quat_x);
      zy_r <= PW'(in_ch.quat_z * in_ch.quat_y);
      zw_r <= PW'(in_ch.quat_z * in_ch.quat_w);
      xy_r <= PW'(in_ch.quat_x * in_ch.quat_y);
      yw_r <= PW'(in_ch.quat_y * in_ch.quat_w);
      zx_r <= PW'(in_ch.quat_z * in_ch.quat_x);
    end
  end

  // atan2 and asin arguments
  args_t args_nxt, args_r, args_d_r;
  logic signed [RW-1:0] s_raw;
  always_comb begin
    args_nxt.rn = (RW'(zy_r) + RW'(wx_r)) <<< 1;
    args_nxt.rd = ONE_Q28 - ((RW'(xx_r) + RW'(yy_r)) <<< 1);
    args_nxt.yn = (RW'(zw_r) + RW'(xy_r)) <<< 1;
    args_nxt.yd = ((RW'(ww_r) + RW'(xx_r)) <<< 1) - ONE_Q28;
    s_raw = (RW'(yw_r) - RW'(zx_r)) <<< 1;
    if (s_raw > ONE_Q28)       args_nxt.s = SW'(ONE_Q28);
    else if (s_raw < -ONE_Q28) args_nxt.s = SW'(-ONE_Q28);
    else                       args_nxt.s = SW'(s_raw);
  end

  logic signed [2*SW-1:0] s_sq;
  logic [VW-1:0] v_r;
  assign s_sq = args_r.s * args_r.s;

  always_ff @(posedge clk) begin
    if (en) begin
      args_r   <= args_nxt;
      args_d_r <= args_r;
      v_r      <= (VW'(1) << 56) - VW'(s_sq);
    end
  end

  // integer square root, two radicand bits per stage
  logic [REMW-1:0] rem_r  [0:SQ_STEPS-1];
  logic [RTW-1:0]  root_r [0:SQ_STEPS-1];
  logic [VW-1:0]   rad_r  [0:SQ_STEPS-1];
  args_t           sq_args_r [0:SQ_STEPS-1];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REMW-1:0] rem_in, rem_sh, trial;
    logic [RTW-1:0]  root_in;
    logic [VW-1:0]   rad_in;
    args_t           args_in;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = v_r;
      assign args_in = args_d_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign args_in = sq_args_r[k-1];
    end
    assign rem_sh = {rem_in[REMW-3:0], rad_in[VW-1 -: 2]};
    assign trial  = REMW'({root_in, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[RTW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[RTW-2:0], 1'b0};
        end
        rad_r[k]     <= rad_in << 2;
        sq_args_r[k] <= args_in;
      end
    end
  end

  args_t a_fin;
  logic signed [CW-1:0] c_ext;
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;
  assign a_fin = sq_args_r[SQ_STEPS-1];
  assign c_ext = CW'({1'b0, root_r[SQ_STEPS-1]});

  qte_cordic u_roll (
    .clk(clk), .en(en),
    .y_in(CW'(a_fin.rn)), .x_in(CW'(a_fin.rd)), .z_out(z_roll)
  );
  qte_cordic u_pitch (
    .clk(clk), .en(en),
    .y_in(CW'(a_fin.s)), .x_in(c_ext), .z_out(z_pitch)
  );
  qte_cordic u_yaw (
    .clk(clk), .en(en),
    .y_in(CW'(a_fin.yn)), .x_in(CW'(a_fin.yd)), .z_out(z_yaw)
  );

  // round Q24 to Q13 and clamp
  function automatic logic signed [ZW-1:0] to_q13(input logic signed [ZW-1:0] a,
                                                  input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] t;
    t = (a + ZW'(1024)) >>> 11;
    if (t > lim)  t = lim;
    if (t < -lim) t = -lim;
    return t;
  endfunction

  logic signed [ZW-1:0] roll_q, pitch_q, yaw_q, cp_q, cr_q;
  always_comb begin
    roll_q  = zq_r[PIPE-1] ? '0 : to_q13(z_roll, PI_Q13);
    pitch_q = zq_r[PIPE-1] ? '0 : to_q13(z_pitch, HALF_PI_Q13);
    yaw_q   = zq_r[PIPE-1] ? '0 : to_q13(z_yaw, PI_Q13);
    cp_q = pitch_q;
    if (cp_q > ONE_RAD_Q13)  cp_q = ONE_RAD_Q13;
    if (cp_q < -ONE_RAD_Q13) cp_q = -ONE_RAD_Q13;
    cr_q = -roll_q;
    if (cr_q > ONE_RAD_Q13)  cr_q = ONE_RAD_Q13;
    if (cr_q < -ONE_RAD_Q13) cr_q = -ONE_RAD_Q13;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pitch_r, cp_r, cr_r;
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_q[15:0];
      pitch_r <= pitch_q[14:0];
      yaw_r   <= yaw_q[15:0];
      cp_r    <= cp_q[14:0];
      cr_r    <= cr_q[14:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.roll_angle  = roll_r;
  assign out_ch.pitch_angle = pitch_r;
  assign out_ch.yaw_angle   = yaw_r;
  assign out_ch.cmd_pitch   = cp_r;
  assign out_ch.cmd_roll    = cr_r;
endmodule
`default_nettype wire

// File: hdl/qte_cordic.sv
`default_nettype none
module qte_cordic (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [qte_pkg::CW-1:0] y_in,
  input  logic signed [qte_pkg::CW-1:0] x_in,
  output logic signed [qte_pkg::ZW-1:0] z_out
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_r [0:CS_USED];
  logic signed [CW-1:0] y_r [0:CS_USED];
  logic signed [ZW-1:0] z_r [0:CS_USED];

  // turn left half-plane vectors by 180 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= (y_in >= 0) ? PI_Q24 : -PI_Q24;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CS_USED; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + atan_q24(i);
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - atan_q24(i);
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  assign z_out = z_r[CS_USED];
endmodule
`default_nettype wire
